>>> rtl/tmcg_pkg.sv
// Shared constants, codes and the stage control struct for the text mode
// character generator. No dependencies.
package tmcg_pkg;

  // Font geometry
  localparam int GLYPH_LINES = 8;
  localparam int GLYPH_COUNT = 256;
  localparam int FONT_COUNT  = 3;
  localparam int MAX_COLUMNS = 80;
  localparam int STORE_DEPTH = FONT_COUNT * GLYPH_COUNT * GLYPH_LINES;
  localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
  localparam int GLYPH_W = 8;

  // Opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Font select codes
  localparam logic [1:0] FONT_NORMAL  = 2'd0;
  localparam logic [1:0] FONT_GRAPHIC = 2'd1;
  localparam logic [1:0] FONT_PCG     = 2'd2;
  localparam logic [1:0] FONT_NONE    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_TEN_LINE_ROWS     = 3'd0;
  localparam logic [2:0] REG_PCG_ENABLE        = 3'd1;
  localparam logic [2:0] REG_CURSOR_VISIBLE    = 3'd2;
  localparam logic [2:0] REG_CURSOR_ROW_POS    = 3'd3;
  localparam logic [2:0] REG_CURSOR_COL_POS    = 3'd4;
  localparam logic [2:0] REG_CURSOR_FIRST_LINE = 3'd5;
  localparam logic [2:0] REG_CURSOR_LAST_LINE  = 3'd6;

  localparam int CFG_DATA_W = 7;

  // Cursor blink: lit while the frame counter is below this
  localparam logic [4:0] BLINK_ON_LIMIT = 5'd15;

  // What the read-back stage does with the glyph byte of one cell
  typedef struct packed {
    logic                 use_glyph;  // take the glyph byte, else const_bits
    logic [GLYPH_W-1:0]   const_bits; // over/underline line in 10-line rows
    logic                 or_ones;    // overline/underline merged in
    logic                 xor_ones;   // cursor inverts the line
    logic [2:0]           fg;
    logic [2:0]           bg;
  } ctrl_t;

endpackage

>>> rtl/text_mode_character_generator.sv
// Text mode character generator: renders one character cell on one scan
// line from three 256-glyph fonts held in one glyph store RAM.
// Depends on tmcg_pkg, tmcg_ram, tmcg_front and tmcg_back.
//
// One transaction is accepted every clock cycle while the output side keeps
// taking results. A render transaction passes through the registered read of
// the glyph store and then the output register. A font write gives no result;
// a glyph line may be rendered in the cycle after it was written. Output
// stalls back up through the two register stages, so up to two results may
// be in flight. The glyph store has no reset and no clearing pass: every
// glyph line must be written before it is displayed. COLUMN_LIMIT is the
// column count of a text row; no cursor is shown at or past it.
module text_mode_character_generator
  import tmcg_pkg::*;
#(
  parameter int COLUMN_LIMIT = MAX_COLUMNS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [7:0]            char_code,
  input  logic [7:0]            attr_byte,
  input  logic [4:0]            text_row,
  input  logic [6:0]            text_col,
  input  logic [3:0]            cell_line,
  input  logic [1:0]            font_sel,
  input  logic [7:0]            font_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_row,
  output logic [2:0]            fg_index,
  output logic [2:0]            bg_index
);

  logic                    take;
  logic                    render;
  logic                    ram_we;
  logic [STORE_ADDR_W-1:0] ram_waddr;
  logic [GLYPH_W-1:0]      ram_wdata;
  logic [STORE_ADDR_W-1:0] ram_raddr;
  logic [GLYPH_W-1:0]      ram_rdata;
  ctrl_t                   ctrl;

  assign take = in_valid && in_ready;

  // Decode and configuration
  tmcg_front #(
    .COLUMN_LIMIT (COLUMN_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .opcode    (opcode),
    .char_code (char_code),
    .attr_byte (attr_byte),
    .text_row  (text_row),
    .text_col  (text_col),
    .cell_line (cell_line),
    .font_sel  (font_sel),
    .font_byte (font_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .render    (render),
    .ram_raddr (ram_raddr),
    .ctrl      (ctrl)
  );

  // Glyph store
  tmcg_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (STORE_DEPTH)
  ) u_glyph_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (render),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Merge and output register
  tmcg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .render    (render),
    .ctrl      (ctrl),
    .rdata     (ram_rdata),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .pixel_row (pixel_row),
    .fg_index  (fg_index),
    .bg_index  (bg_index)
  );

endmodule

>>> rtl/tmcg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read
// that holds its data while the read enable is low. No dependencies.
module tmcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tmcg_front.sv
// Front stage: configuration registers, blink counter and the decode of one
// accepted transaction into glyph store accesses and a control word.
// Depends on tmcg_pkg.
module tmcg_front
  import tmcg_pkg::*;
#(
  parameter int COLUMN_LIMIT = MAX_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    take,
  input  logic                    opcode,
  input  logic [7:0]              char_code,
  input  logic [7:0]              attr_byte,
  input  logic [4:0]              text_row,
  input  logic [6:0]              text_col,
  input  logic [3:0]              cell_line,
  input  logic [1:0]              font_sel,
  input  logic [7:0]              font_byte,
  output logic                    ram_we,
  output logic [STORE_ADDR_W-1:0] ram_waddr,
  output logic [GLYPH_W-1:0]      ram_wdata,
  output logic                    render,
  output logic [STORE_ADDR_W-1:0] ram_raddr,
  output ctrl_t                   ctrl
);

  logic       ten_line_rows;
  logic       pcg_enable;
  logic       cursor_visible;
  logic [4:0] cursor_row_pos;
  logic [6:0] cursor_col_pos;
  logic [3:0] cursor_first_line;
  logic [3:0] cursor_last_line;
  logic [4:0] blink_counter;
  logic [4:0] blink_counter_next;

  logic       frame_start;
  logic       cursor_here;
  logic [1:0] font;
  logic [2:0] gl;
  logic [3:0] gl_ext;
  logic [3:0] cur_height;
  logic       shape_ok;
  logic       shape_moved;
  logic       line_lit;
  logic       over;
  logic       under;
  logic       reverse;
  logic       erase;
  logic [2:0] colour;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ten_line_rows     <= 1'b0;
      pcg_enable        <= 1'b0;
      cursor_visible    <= 1'b0;
      cursor_row_pos    <= '0;
      cursor_col_pos    <= '0;
      cursor_first_line <= '0;
      cursor_last_line  <= 4'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEN_LINE_ROWS:     ten_line_rows     <= cfg_data[0];
        REG_PCG_ENABLE:        pcg_enable        <= cfg_data[0];
        REG_CURSOR_VISIBLE:    cursor_visible    <= cfg_data[0];
        REG_CURSOR_ROW_POS:    cursor_row_pos    <= cfg_data[4:0];
        REG_CURSOR_COL_POS:    cursor_col_pos    <= cfg_data[6:0];
        REG_CURSOR_FIRST_LINE: cursor_first_line <= cfg_data[3:0];
        REG_CURSOR_LAST_LINE:  cursor_last_line  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Advance the blink counter at the top-left cell of a frame
  assign render      = take && (opcode == OP_RENDER);
  assign frame_start = (text_row == 5'd0) && (cell_line == 4'd0) && (text_col == 7'd0);
  assign blink_counter_next = frame_start ? blink_counter + 5'd1 : blink_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_counter <= '0;
    end else if (render) begin
      blink_counter <= blink_counter_next;
    end
  end

  // Font write: drop bad font selects and lines past the glyph
  assign ram_we    = take && (opcode == OP_WRITE) && (font_sel != FONT_NONE) && !cell_line[3];
  assign ram_waddr = {font_sel, char_code, cell_line[2:0]};
  assign ram_wdata = font_byte;

  // Glyph read address
  assign font   = pcg_enable ? FONT_PCG : (attr_byte[4] ? FONT_GRAPHIC : FONT_NORMAL);
  assign gl_ext = ten_line_rows ? cell_line - 4'd1 : {1'b0, cell_line[2:0]};
  assign gl     = gl_ext[2:0];
  assign ram_raddr = {font, char_code, gl};

  // Cursor block, moved up to end on the last glyph line when it runs past
  assign cur_height  = cursor_last_line - cursor_first_line;
  assign shape_ok    = cursor_first_line <= cursor_last_line;
  assign shape_moved = shape_ok && cursor_last_line[3];

  always_comb begin
    if (shape_moved) begin
      line_lit = (cur_height <= 4'd7) && ({1'b0, gl} >= 4'd7 - cur_height);
    end else begin
      line_lit = shape_ok && ({1'b0, gl} >= cursor_first_line) &&
                 ({1'b0, gl} <= cursor_last_line);
    end
  end

  assign cursor_here = cursor_visible && (blink_counter_next < BLINK_ON_LIMIT) &&
                       (text_row == cursor_row_pos) && (text_col == cursor_col_pos) &&
                       ({25'd0, text_col} < COLUMN_LIMIT);

  // Attributes and colours
  assign over    = attr_byte[3];
  assign reverse = attr_byte[5];
  assign erase   = attr_byte[6];
  assign under   = attr_byte[7];
  assign colour  = attr_byte[2:0];

  always_comb begin
    ctrl.fg = (reverse == erase) ? colour : 3'd0;
    ctrl.bg = reverse ? colour : 3'd0;
    ctrl.const_bits = '0;
    ctrl.or_ones    = 1'b0;
    ctrl.xor_ones   = 1'b0;
    ctrl.use_glyph  = 1'b1;
    if (ten_line_rows) begin
      if (cell_line == 4'd0) begin
        ctrl.use_glyph  = 1'b0;
        ctrl.const_bits = {GLYPH_W{over}};
      end else if (cell_line == 4'd9) begin
        ctrl.use_glyph  = 1'b0;
        ctrl.const_bits = {GLYPH_W{under}};
      end else if (cell_line > 4'd9) begin
        ctrl.use_glyph  = 1'b0;
      end else begin
        ctrl.xor_ones = cursor_here && line_lit;
      end
    end else begin
      ctrl.or_ones  = ((gl == 3'd0) && over) || ((gl == 3'd7) && under);
      ctrl.xor_ones = cursor_here && line_lit;
    end
  end

endmodule

>>> rtl/tmcg_back.sv
// Back stage: holds the control word while the glyph read completes, then
// merges it with the glyph byte into the output register. Handles flow
// control for both channels. Depends on tmcg_pkg.
module tmcg_back
  import tmcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               render,
  input  ctrl_t              ctrl,
  input  logic [GLYPH_W-1:0] rdata,
  input  logic               out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output logic [7:0]         pixel_row,
  output logic [2:0]         fg_index,
  output logic [2:0]         bg_index
);

  logic               s1_valid;
  ctrl_t              s1_ctrl;
  logic               advance;
  logic [GLYPH_W-1:0] bits;

  // Output register frees up when empty or taken this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (in_ready) begin
        s1_valid <= render;
      end
    end
  end

  // Hold the control word alongside the pending glyph read
  always_ff @(posedge clk) begin
    if (in_ready && render) begin
      s1_ctrl <= ctrl;
    end
  end

  // Merge glyph byte, line attributes and cursor
  assign bits = s1_ctrl.use_glyph ?
                ((rdata | {GLYPH_W{s1_ctrl.or_ones}}) ^ {GLYPH_W{s1_ctrl.xor_ones}}) :
                s1_ctrl.const_bits;

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      pixel_row <= bits;
      fg_index  <= s1_ctrl.fg;
      bg_index  <= s1_ctrl.bg;
    end
  end

endmodule

>>> rtl/tmcg_checker.sv
// Port-level checks for the text mode character generator, bound to the
// top level. Depends on text_mode_character_generator.
module tmcg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel_row,
  input logic [2:0] fg_index,
  input logic [2:0] bg_index
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_row) &&
    $stable(fg_index) && $stable(bg_index))
    else $error("stalled result changed");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // Render reaches the output register when the sink takes results
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode) ##1 out_ready |=> out_valid)
    else $error("render transaction did not reach the output");

  // Distinct colours only when one of them is black
  a_colours: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fg_index != bg_index) |-> (fg_index == 3'd0) || (bg_index == 3'd0))
    else $error("colour pair not reachable by attributes");

endmodule

bind text_mode_character_generator tmcg_checker u_tmcg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pixel_row (pixel_row),
  .fg_index  (fg_index),
  .bg_index  (bg_index)
);

>>> dv/tb.sv
// Self-checking testbench for text_mode_character_generator: font writes and
// cell renders against a scan-line predictor, with random stalls on both sides.
// Depends on tmcg_pkg and the text_mode_character_generator RTL.
module tb
  import tmcg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int WRITE_SETTLE = 4;
  localparam int FONT_SPAN    = GLYPH_COUNT * GLYPH_LINES;

  typedef struct packed {
    logic       opcode;
    logic [7:0] code;
    logic [7:0] attr;
    logic [4:0] row;
    logic [6:0] col;
    logic [3:0] line;
    logic [1:0] fsel;
    logic [7:0] fbyte;
  } cell_req_t;

  typedef struct packed {
    logic [7:0] pixels;
    logic [2:0] fg;
    logic [2:0] bg;
  } scan_pixels_t;

  // DUT ports, every input known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = OP_WRITE;
  logic [7:0]            char_code = '0;
  logic [7:0]            attr_byte = '0;
  logic [4:0]            text_row = '0;
  logic [6:0]            text_col = '0;
  logic [3:0]            cell_line = '0;
  logic [1:0]            font_sel = FONT_NORMAL;
  logic [7:0]            font_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [7:0]            pixel_row;
  logic [2:0]            fg_index;
  logic [2:0]            bg_index;

  // Predictor state: register copies, blink counter and glyph store mirror
  logic       cfg_ten = 1'b0;
  logic       cfg_pcg = 1'b0;
  logic       cfg_vis = 1'b0;
  logic [4:0] cfg_row = '0;
  logic [6:0] cfg_col = '0;
  logic [3:0] cfg_first = '0;
  logic [3:0] cfg_last = 4'd7;
  logic [4:0] blink_count = '0;
  logic [7:0] glyph_mirror [STORE_DEPTH];
  bit         glyph_known [STORE_DEPTH];

  scan_pixels_t pending_pixels [$];

  // Receiver control and run statistics
  bit rx_stalls = 1'b0;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int renders = 0;
  int font_writes = 0;
  int writes_dropped = 0;
  int frame_starts = 0;
  int cursor_lines = 0;
  int quiet_cycles = 0;

  text_mode_character_generator DUT (.*);

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out which glyph byte a render reads; zero when it reads none
  function automatic bit glyph_line_of(input cell_req_t r, output int addr, output int gl);
    int font;
    addr = 0;
    gl = 0;
    font = int'(cfg_pcg ? FONT_PCG : (r.attr[4] ? FONT_GRAPHIC : FONT_NORMAL));
    if (cfg_ten) begin
      if (r.line == 0 || r.line >= 9) return 1'b0;
      gl = r.line - 1;
    end else begin
      gl = r.line % GLYPH_LINES;
    end
    addr = (font * GLYPH_COUNT + r.code) * GLYPH_LINES + gl;
    return 1'b1;
  endfunction

  // Cursor block, moved up to end at the last glyph line when it runs past it
  function automatic bit cursor_on_line(input int gl);
    int first;
    int last;
    int h;
    first = int'(cfg_first);
    last = int'(cfg_last);
    if (first <= last && last >= GLYPH_LINES) begin
      h = last - first;
      last = GLYPH_LINES - 1;
      first = last - h;
    end
    return last >= first && first >= 0 && first < GLYPH_LINES && last < GLYPH_LINES &&
           gl >= first && gl <= last;
  endfunction

  // Apply one accepted transaction to the predictor and queue the scan line of a render
  task automatic predict_scanline(input cell_req_t r);
    int addr;
    int gl;
    logic [2:0] colour;
    bit lit;
    scan_pixels_t want;
    if (r.opcode == OP_WRITE) begin
      font_writes++;
      if (r.fsel != FONT_NONE && r.line < GLYPH_LINES) begin
        addr = (r.fsel * GLYPH_COUNT + r.code) * GLYPH_LINES + r.line;
        glyph_mirror[addr] = r.fbyte;
        glyph_known[addr] = 1'b1;
      end else begin
        writes_dropped++;
      end
      return;
    end
    renders++;
    if (r.row == 0 && r.col == 0 && r.line == 0) begin
      blink_count = blink_count + 5'd1;
      frame_starts++;
    end
    colour = r.attr[2:0];
    want.bg = r.attr[5] ? colour : 3'd0;
    want.fg = (r.attr[5] == r.attr[6]) ? colour : 3'd0;
    lit = cfg_vis && blink_count < BLINK_ON_LIMIT && r.row == cfg_row &&
          r.col == cfg_col && r.col < MAX_COLUMNS;
    if (glyph_line_of(r, addr, gl)) begin
      want.pixels = glyph_mirror[addr];
      if (!cfg_ten && gl == 0 && r.attr[3]) want.pixels = 8'hFF;
      if (!cfg_ten && gl == GLYPH_LINES - 1 && r.attr[7]) want.pixels = 8'hFF;
      if (lit && cursor_on_line(gl)) begin
        want.pixels = want.pixels ^ 8'hFF;
        cursor_lines++;
      end
    end else begin
      want.pixels = ((r.line == 0 && r.attr[3]) || (r.line == 9 && r.attr[7])) ? 8'hFF : 8'h00;
    end
    pending_pixels.push_back(want);
  endtask

  // Offer one transaction and hold it until accepted
  task automatic drive_cell(input cell_req_t r);
    @(negedge clk);
    in_valid = 1'b1;
    opcode = r.opcode;
    char_code = r.code;
    attr_byte = r.attr;
    text_row = r.row;
    text_col = r.col;
    cell_line = r.line;
    font_sel = r.fsel;
    font_byte = r.fbyte;
    do @(posedge clk); while (!in_ready);
    predict_scanline(r);
  endtask

  // Send a transaction, writing its glyph line first if it was never written
  task automatic send_cell(input cell_req_t r);
    int addr;
    int gl;
    cell_req_t w;
    if (r.opcode == OP_RENDER && glyph_line_of(r, addr, gl) && !glyph_known[addr]) begin
      w = r;
      w.opcode = OP_WRITE;
      w.fsel = 2'(addr / FONT_SPAN);
      w.line = 4'(gl);
      w.fbyte = 8'($urandom);
      drive_cell(w);
    end
    drive_cell(r);
  endtask

  function automatic cell_req_t render_req(input logic [7:0] code, input logic [7:0] attr,
                                           input logic [4:0] row, input logic [6:0] col,
                                           input logic [3:0] line);
    cell_req_t r;
    r.opcode = OP_RENDER;
    r.code = code;
    r.attr = attr;
    r.row = row;
    r.col = col;
    r.line = line;
    r.fsel = 2'($urandom_range(0, 3));
    r.fbyte = 8'($urandom);
    return r;
  endfunction

  function automatic cell_req_t write_req(input logic [1:0] fsel, input logic [7:0] code,
                                          input logic [3:0] line, input logic [7:0] fbyte);
    cell_req_t r;
    r.opcode = OP_WRITE;
    r.code = code;
    r.attr = 8'($urandom);
    r.row = 5'($urandom_range(0, 24));
    r.col = 7'($urandom_range(0, 79));
    r.line = line;
    r.fsel = fsel;
    r.fbyte = fbyte;
    return r;
  endfunction

  // Drop valid; n sets how long
  task automatic hold_back_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Drop valid and wait until every queued scan line has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_TEN_LINE_ROWS:     cfg_ten = val[0];
      REG_PCG_ENABLE:        cfg_pcg = val[0];
      REG_CURSOR_VISIBLE:    cfg_vis = val[0];
      REG_CURSOR_ROW_POS:    cfg_row = val[4:0];
      REG_CURSOR_COL_POS:    cfg_col = val[6:0];
      REG_CURSOR_FIRST_LINE: cfg_first = val[3:0];
      REG_CURSOR_LAST_LINE:  cfg_last = val[3:0];
      default: ;
    endcase
  endtask

  // Reprogram every register once the block has gone idle
  task automatic configure(input logic ten, input logic pcg, input logic vis,
                           input logic [4:0] row, input logic [6:0] col,
                           input logic [3:0] first, input logic [3:0] last);
    drain_results();
    repeat (WRITE_SETTLE) @(posedge clk);
    write_reg(REG_TEN_LINE_ROWS, CFG_DATA_W'(ten));
    write_reg(REG_PCG_ENABLE, CFG_DATA_W'(pcg));
    write_reg(REG_CURSOR_VISIBLE, CFG_DATA_W'(vis));
    write_reg(REG_CURSOR_ROW_POS, CFG_DATA_W'(row));
    write_reg(REG_CURSOR_COL_POS, CFG_DATA_W'(col));
    write_reg(REG_CURSOR_FIRST_LINE, CFG_DATA_W'(first));
    write_reg(REG_CURSOR_LAST_LINE, CFG_DATA_W'(last));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Reprogram every register with random values, cursor shown
  task automatic configure_random();
    configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
              5'($urandom_range(0, 24)), 7'($urandom_range(0, 79)),
              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endtask

  // Mostly renders with random content, biased to frame starts and the cursor cell
  task automatic random_cell(output cell_req_t r);
    int pick;
    r = render_req(8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255)),
                   8'($urandom), 5'($urandom_range(0, 24)), 7'($urandom_range(0, 79)),
                   4'($urandom_range(0, 9)));
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      r.opcode = OP_WRITE;
      r.fsel = 2'($urandom_range(0, 2));
      r.line = 4'($urandom_range(0, GLYPH_LINES - 1));
    end else if (pick < 21) begin
      // write that the block must drop
      r.opcode = OP_WRITE;
      if ($urandom_range(0, 1)) r.fsel = FONT_NONE;
      else r.line = 4'($urandom_range(8, 9));
    end else if (pick < 35) begin
      r.row = 5'd0;
      r.col = 7'd0;
      r.line = 4'd0;
    end else if (pick < 60) begin
      r.row = cfg_row;
      r.col = cfg_col;
    end else if (pick < 64) begin
      r.line = 4'($urandom_range(10, 15));
    end
  endtask

  task automatic random_traffic(input int n, input bit gaps);
    cell_req_t r;
    for (int i = 0; i < n; i++) begin
      if (gaps && (i % 64) >= 16 && $urandom_range(0, 7) == 0)
        hold_back_sender($urandom_range(1, 13));
      random_cell(r);
      send_cell(r);
    end
  endtask

  // Glyph writes to each font, dropped writes, then a frame-start render
  task automatic test_font_writes();
    send_cell(write_req(FONT_NORMAL, 8'h00, 4'd0, 8'h3C));
    send_cell(write_req(FONT_NORMAL, 8'hFF, 4'd7, 8'h81));
    send_cell(write_req(FONT_GRAPHIC, 8'h80, 4'd0, 8'hA5));
    send_cell(write_req(FONT_PCG, 8'h01, 4'd3, 8'h5A));
    send_cell(write_req(FONT_NONE, 8'h00, 4'd0, 8'hFF));
    send_cell(write_req(FONT_NORMAL, 8'h00, 4'd8, 8'hFF));
    send_cell(write_req(FONT_NORMAL, 8'hFF, 4'd9, 8'h00));
    send_cell(render_req(8'h00, 8'h00, 5'd0, 7'd0, 4'd0));
  endtask

  // Overline, underline, reverse, erase and graphic font in eight-line rows
  task automatic test_attributes();
    send_cell(render_req(8'h00, 8'h0F, 5'd24, 7'd79, 4'd0));
    send_cell(render_req(8'h00, 8'h25, 5'd3, 7'd10, 4'd8));
    send_cell(render_req(8'hFF, 8'h43, 5'd7, 7'd1, 4'd7));
    send_cell(render_req(8'hFF, 8'hE6, 5'd24, 7'd0, 4'd7));
    send_cell(render_req(8'h80, 8'h11, 5'd16, 7'd64, 4'd0));
  endtask

  // Ten-line rows with the programmable font and a cursor at the last cell
  task automatic test_ten_line_rows();
    configure(1'b1, 1'b1, 1'b1, 5'd24, 7'd79, 4'd2, 4'd9);
    send_cell(render_req(8'h01, 8'h01, 5'd24, 7'd79, 4'd4));
    send_cell(render_req(8'h01, 8'h88, 5'd24, 7'd79, 4'd0));
    send_cell(render_req(8'h01, 8'h80, 5'd24, 7'd79, 4'd9));
    send_cell(render_req(8'h01, 8'h08, 5'd24, 7'd79, 4'd9));
    send_cell(render_req(8'h01, 8'hFF, 5'd24, 7'd79, 4'd12));
    send_cell(render_req(8'h01, 8'h01, 5'd23, 7'd79, 4'd4));
  endtask

  // Long receiver hold-off while items keep coming, then a full drain pause
  task automatic test_backpressure();
    hold_req = 1'b1;
    random_traffic(30, 1'b0);
    drain_results();
    random_traffic(20, 1'b0);
  endtask

  // Random traffic over several register settings, extremes included
  task automatic test_random_settings();
    rx_stalls = 1'b1;
    configure(1'b0, 1'b0, 1'b1, 5'd0, 7'd0, 4'd0, 4'd7);
    random_traffic(160, 1'b1);
    configure(1'b1, 1'b0, 1'b1, 5'd24, 7'd79, 4'd15, 4'd15);
    random_traffic(160, 1'b1);
    configure(1'b0, 1'b1, 1'b1, 5'd12, 7'd40, 4'd3, 4'd12);
    random_traffic(160, 1'b1);
    configure(1'b1, 1'b1, 1'b1, 5'd5, 7'd3, 4'd6, 4'd2);
    random_traffic(160, 1'b1);
    configure_random();
    random_traffic(160, 1'b1);
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    rx_stalls = 1'b0;
    configure_random();
    random_traffic(150, 1'b0);
  endtask

  // Receiver: long hold-off on request, random stall bursts, otherwise ready
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Compare each result transaction with the oldest expected scan line
  always @(posedge clk) begin : check_results
    scan_pixels_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: unexpected result pixels %h fg %0d bg %0d",
                   $realtime, pixel_row, fg_index, bg_index);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_row !== want.pixels || fg_index !== want.fg || bg_index !== want.bg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: mismatch: expected pixels %h fg %0d bg %0d, got %h fg %0d bg %0d",
                     $realtime, want.pixels, want.fg, want.bg, pixel_row, fg_index, bg_index);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Sequence the tests
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_font_writes();
    test_attributes();
    test_ten_line_rows();
    test_backpressure();
    test_random_settings();
    test_full_rate();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d renders (%0d frame starts, %0d cursor-inverted lines), %0d font writes",
             renders, frame_starts, cursor_lines, font_writes);
    $display("%0d writes dropped, %0d results compared, %0d mismatches, %0d still awaited",
             writes_dropped, results_seen, mismatches, pending_pixels.size());
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
